// ===== src/plr_pkg.sv =====
// Shared types and constants for the page line rasterizer.
// No dependencies; used by plr_ctrl, plr_datapath and page_line_rasterizer.
`default_nettype none

package plr_pkg;

  localparam int unsigned CLEAR_BYTE_COUNT = 1024;
  localparam int unsigned REPEAT_MAX       = 2047;
  localparam int unsigned MAX_VERT_LEN     = 128;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OP_W       = 2;

  typedef enum logic [1:0] {
    OP_HLINE = 2'd0,
    OP_VLINE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } plr_op_e;

  typedef struct packed {
    logic load;   // latch a new command
    logic step;   // emit the current run into the output register
  } plr_cmd_t;

  typedef struct packed {
    logic last;   // current run is the final one of the command
  } plr_status_t;

endpackage

`default_nettype wire

// ===== src/plr_ctrl.sv =====
// Command sequencer for the page line rasterizer: state machine and output valid.
// Depends on plr_pkg; drives plr_datapath through plr_cmd_t.
`default_nettype none

module plr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [1:0]          in_op_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output plr_pkg::plr_cmd_t   cmd_o,
  input  plr_pkg::plr_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (in_op_i != plr_pkg::OP_NONE) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_step_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> state_q == ST_RUN)
    else $error("run emitted outside RUN state");

  a_unused_op_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op_i == plr_pkg::OP_NONE |=> state_q == ST_IDLE && !cmd_o.step)
    else $error("unused opcode started a command");

  a_valid_op_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op_i != plr_pkg::OP_NONE |=> state_q == ST_RUN)
    else $error("command accepted but no run started");

  a_last_step_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && status_i.last |=> in_ready_o && out_valid_o)
    else $error("final run did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== src/plr_datapath.sv =====
// Datapath of the page line rasterizer: command decode, mask math, page counter
// and output payload register. Depends on plr_pkg; controlled by plr_ctrl.
`default_nettype none

module plr_datapath #(
  parameter int unsigned ClearByteCount = plr_pkg::CLEAR_BYTE_COUNT
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_wdata_i,
  input  wire  [1:0]           op_i,
  input  wire  [6:0]           col_i,
  input  wire  [5:0]           row_i,
  input  wire  [7:0]           len_i,
  input  plr_pkg::plr_cmd_t    cmd_i,
  output plr_pkg::plr_status_t status_o,
  output logic [4:0]           page_o,
  output logic [6:0]           col_o,
  output logic [7:0]           pattern_o,
  output logic [10:0]          repeat_o,
  output logic                 last_o
);

  localparam int unsigned ClearRep = (ClearByteCount > plr_pkg::REPEAT_MAX) ?
                                     plr_pkg::REPEAT_MAX : ClearByteCount;
  localparam logic [10:0] ClearRepW = 11'(ClearRep);

  logic        end_mask_fixed_q;
  logic [4:0]  page_q, page_d;
  logic [4:0]  last_page_q, last_page_d;
  logic [6:0]  col_q, col_d;
  logic [7:0]  smask_q, smask_d;
  logic [7:0]  emask_q, emask_d;
  logic        first_q, first_d;
  logic [10:0] rep_q, rep_d;

  logic [7:0]  vlen;
  logic [7:0]  row_end;
  logic [2:0]  e;
  logic [7:0]  emask_v;
  logic        is_last;
  logic [7:0]  pattern;

  plr_pkg::plr_op_e op;

  assign op      = plr_pkg::plr_op_e'(op_i);
  assign vlen    = (len_i > 8'(plr_pkg::MAX_VERT_LEN)) ? 8'(plr_pkg::MAX_VERT_LEN) : len_i;
  assign row_end = {2'b00, row_i} + vlen;
  assign e       = row_end[2:0];
  assign emask_v = end_mask_fixed_q ? 8'((9'd1 << e) - 9'd1) : (8'hFF >> e);

  always_comb begin
    page_d      = page_q;
    last_page_d = last_page_q;
    col_d       = col_q;
    smask_d     = smask_q;
    emask_d     = emask_q;
    first_d     = first_q;
    rep_d       = rep_q;
    if (cmd_i.load) begin
      first_d = 1'b1;
      unique case (op) inside
        plr_pkg::OP_HLINE: begin
          page_d      = {2'b00, row_i[5:3]};
          last_page_d = {2'b00, row_i[5:3]};
          col_d       = col_i;
          smask_d     = 8'h01 << row_i[2:0];
          emask_d     = 8'hFF;
          rep_d       = {3'b000, len_i};
        end
        plr_pkg::OP_VLINE: begin
          page_d      = {2'b00, row_i[5:3]};
          last_page_d = row_end[7:3];
          col_d       = col_i;
          smask_d     = 8'hFF << row_i[2:0];
          emask_d     = emask_v;
          rep_d       = 11'd1;
        end
        plr_pkg::OP_CLEAR, plr_pkg::OP_NONE: begin
          page_d      = 5'd0;
          last_page_d = 5'd0;
          col_d       = 7'd0;
          smask_d     = 8'h00;
          emask_d     = 8'hFF;
          rep_d       = ClearRepW;
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      first_d = 1'b0;
      page_d  = page_q + 5'd1;
    end
  end

  assign is_last       = (page_q == last_page_q);
  assign status_o.last = is_last;

  always_comb begin
    case ({first_q, is_last})
      2'b11:   pattern = smask_q & emask_q;
      2'b10:   pattern = smask_q;
      2'b01:   pattern = emask_q;
      default: pattern = 8'hFF;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_mask_fixed_q <= 1'b1;
    end else if (cfg_we_i) begin
      end_mask_fixed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    last_page_q <= last_page_d;
    col_q       <= col_d;
    smask_q     <= smask_d;
    emask_q     <= emask_d;
    first_q     <= first_d;
    rep_q       <= rep_d;
    if (cmd_i.step) begin
      page_o    <= page_q;
      col_o     <= col_q;
      pattern_o <= pattern;
      repeat_o  <= rep_q;
      last_o    <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_page_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> page_q <= last_page_q && last_page_q <= 5'd23)
    else $error("page counter ran past the last page");

  a_middle_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !first_q && !is_last |=> pattern_o == 8'hFF)
    else $error("middle page not fully set");

  a_later_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !first_q |-> rep_q == 11'd1)
    else $error("later run of a command is not one column wide");
`endif

endmodule

`default_nettype wire

// ===== src/page_line_rasterizer.sv =====
// Page line rasterizer: turns draw commands into page-mode write runs for an
// 8-pixel-per-byte display. Depends on plr_pkg, plr_ctrl and plr_datapath.
//
// Slave stream: one beat per command. tuser carries the opcode (horizontal,
// vertical, clear; the fourth code is taken and dropped). Master stream: one
// beat per run, tlast on the final run of a command.
// Config: cfg_we_i with cfg_wdata_i selects the end-mask formula (1 = fixed,
// reset value); users must write it only while the block is idle (unchecked).
// Timing: on acceptance the command registers are loaded and the sequencer
// enters RUN; its runs are then produced one per cycle by the page counter
// while the output register is free or being taken, each step loading the
// output register. A command has 1 to 17 runs. s_axis_tready is high only
// between commands. The output register holds a beat while m_axis_tready is
// low and the sequencer waits; the next command can be taken while the final
// run of the previous one still sits in the output register.
// Reset clears the sequencer and output valid and sets the end-mask register.
`default_nettype none

module page_line_rasterizer #(
  parameter int unsigned ClearByteCount = plr_pkg::CLEAR_BYTE_COUNT
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire                               cfg_wdata_i,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // [6:0] start_column, [12:7] start_row, [20:13] line_length, [23:21] zero
  input  wire  [plr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] opcode
  input  wire  [plr_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [4:0] page_index, [11:5] column_index, [19:12] pattern_byte,
  // [30:20] repeat_count, [31] zero
  output logic [plr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  plr_pkg::plr_cmd_t    cmd;
  plr_pkg::plr_status_t status;
  logic [4:0]           page;
  logic [6:0]           col;
  logic [7:0]           pattern;
  logic [10:0]          rep;

  plr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  plr_datapath #(
    .ClearByteCount (ClearByteCount)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser),
    .col_i       (s_axis_tdata[6:0]),
    .row_i       (s_axis_tdata[12:7]),
    .len_i       (s_axis_tdata[20:13]),
    .cmd_i       (cmd),
    .status_o    (status),
    .page_o      (page),
    .col_o       (col),
    .pattern_o   (pattern),
    .repeat_o    (rep),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, rep, pattern, col, page};

endmodule

`default_nettype wire
